// ----- sv/wtcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wtcs_pkg
// Shared types, constants and helpers for the wall texture coordinate stepper.
// ----------------------------------------------------------------------------
package wtcs_pkg;

  // Field widths
  localparam int FRAC_W   = 16;
  localparam int HEIGHT_W = 16;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 10;
  localparam int SEL_W    = 2;
  localparam int TEX_W    = 10;
  localparam int WIDTH_W  = 11;
  localparam int HLOG_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EAST_WIDTH        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEST_WIDTH        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_WIDTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EAST_HEIGHT_LOG2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEST_HEIGHT_LOG2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_HEIGHT_LOG2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_HEIGHT_LOG2 = 3'd7;

  // Texture select codes
  localparam logic [SEL_W-1:0] FACE_EAST  = 2'd0;
  localparam logic [SEL_W-1:0] FACE_WEST  = 2'd1;
  localparam logic [SEL_W-1:0] FACE_SOUTH = 2'd2;
  localparam logic [SEL_W-1:0] FACE_NORTH = 2'd3;

  // Register reset values
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd64;
  localparam logic [HLOG_W-1:0]  HLOG_RESET  = 4'd6;
  localparam logic [HLOG_W-1:0]  HLOG_MAX    = 4'd10;

  // Fixed point: 11.16 step, 32.16 position
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 27;
  localparam int POS_W     = 48;
  localparam int DIV_BITS  = STEP_W;

  localparam int SCREEN_HEIGHT_DEFAULT = 1024;

  // Datapath commands
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic setup;
    logic div_step;
    logic mul;
    logic emit;
  } wtcs_cmd_t;

  // Datapath status
  typedef struct packed {
    logic out_full;
  } wtcs_stat_t;

  // Clamp a height log2 to the largest supported texture
  function automatic logic [HLOG_W-1:0] sat_log2(input logic [HLOG_W-1:0] l);
    sat_log2 = (l > HLOG_MAX) ? HLOG_MAX : l;
  endfunction

endpackage

// ----- sv/wtcs_if.sv -----
// ----------------------------------------------------------------------------
// wtcs_if
// Valid/ready channels: pixel input word, texel output word, register writes.
// ----------------------------------------------------------------------------
interface wtcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          first_row;
  logic                          hit_side;
  logic                          ray_x_positive;
  logic                          ray_y_positive;
  logic [wtcs_pkg::FRAC_W-1:0]   wall_fraction;
  logic [wtcs_pkg::HEIGHT_W-1:0] wall_height;
  logic [wtcs_pkg::COL_W-1:0]    column;
  logic [wtcs_pkg::ROW_W-1:0]    row;

  modport source (output valid, first_row, hit_side, ray_x_positive, ray_y_positive,
                  wall_fraction, wall_height, column, row, input ready);
  modport sink   (input valid, first_row, hit_side, ray_x_positive, ray_y_positive,
                  wall_fraction, wall_height, column, row, output ready);
endinterface

interface wtcs_out_if;
  logic                       valid;
  logic                       ready;
  logic [wtcs_pkg::SEL_W-1:0] texture_select;
  logic [wtcs_pkg::TEX_W-1:0] texture_x;
  logic [wtcs_pkg::TEX_W-1:0] texture_y;
  logic [wtcs_pkg::COL_W-1:0] out_column;
  logic [wtcs_pkg::ROW_W-1:0] out_row;

  modport source (output valid, texture_select, texture_x, texture_y, out_column,
                  out_row, input ready);
  modport sink   (input valid, texture_select, texture_x, texture_y, out_column,
                  out_row, output ready);
endinterface

interface wtcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wtcs_pkg::CFG_IDX_W-1:0]  index;
  logic [wtcs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/wall_texture_coordinate_stepper.sv -----
// ----------------------------------------------------------------------------
// wall_texture_coordinate_stepper
// A row word goes from capture to emit; a first-row word runs column setup,
// the 27-iteration restoring divider that forms the 11.16 vertical step and
// the start multiply before emit. Emit waits while the output is stalled.
// Input is taken only in idle; a new word is taken while a result waits.
// Reset (rst, synchronous): config to 64 wide / log2 height 6, state cleared.
// ----------------------------------------------------------------------------
module wall_texture_coordinate_stepper #(
  parameter int SCREEN_HEIGHT = wtcs_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  wtcs_in_if.sink    pixel_in,
  wtcs_out_if.source pixel_out,
  wtcs_cfg_if.sink   cfg
);

  wtcs_pkg::wtcs_cmd_t  cmd;
  wtcs_pkg::wtcs_stat_t stat;

  // Sequencer
  wtcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pixel_in.valid),
    .in_first_row (pixel_in.first_row),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Arithmetic and storage
  wtcs_dp #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out),
    .cfg       (cfg)
  );

endmodule

// ----- sv/wtcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtcs_ctrl
// Sequencer: accept a word, run column setup, the step divider and the start
// multiply on a first row, then emit one result word.
// ----------------------------------------------------------------------------
module wtcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_first_row,
  input  wtcs_pkg::wtcs_stat_t stat,
  output wtcs_pkg::wtcs_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam int CNT_W = $clog2(wtcs_pkg::DIV_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wtcs_pkg::DIV_BITS - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] div_cnt;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = in_first_row ? ST_SETUP : ST_EMIT;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == CNT_LAST) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count divider iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.setup) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

endmodule

// ----- sv/wtcs_dp.sv -----
// ----------------------------------------------------------------------------
// wtcs_dp
// Datapath: configuration registers, texture pick and texel column, restoring
// step divider, start position multiply, position stepping, output register.
// ----------------------------------------------------------------------------
module wtcs_dp #(
  parameter int SCREEN_HEIGHT = wtcs_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wtcs_pkg::wtcs_cmd_t  cmd,
  output wtcs_pkg::wtcs_stat_t stat,
  wtcs_in_if.sink              pixel_in,
  wtcs_out_if.source           pixel_out,
  wtcs_cfg_if.sink             cfg
);

  localparam int SH_LOG2 = $clog2(SCREEN_HEIGHT);
  localparam int OFS_W   = ((SH_LOG2 > wtcs_pkg::HEIGHT_W) ? SH_LOG2 : wtcs_pkg::HEIGHT_W) + 1;
  localparam int STEP_W  = wtcs_pkg::STEP_W;
  localparam int POS_W   = wtcs_pkg::POS_W;
  localparam int PROD_W  = OFS_W + STEP_W + 1;
  localparam int TXP_W   = wtcs_pkg::FRAC_W + wtcs_pkg::WIDTH_W;
  localparam int HW      = wtcs_pkg::HEIGHT_W;

  // Configuration registers
  logic [wtcs_pkg::WIDTH_W-1:0] cfg_width [4];
  logic [wtcs_pkg::HLOG_W-1:0]  cfg_hlog  [4];

  // Captured input word
  logic                          it_side;
  logic                          it_xpos;
  logic                          it_ypos;
  logic [wtcs_pkg::FRAC_W-1:0]   it_frac;
  logic [HW-1:0]                 it_h;
  logic [wtcs_pkg::COL_W-1:0]    it_col;
  logic [wtcs_pkg::ROW_W-1:0]    it_row;

  // Column state
  logic [wtcs_pkg::SEL_W-1:0]    current_texture;
  logic [wtcs_pkg::TEX_W-1:0]    texel_column;
  logic [STEP_W-1:0]             position_step;
  logic [POS_W-1:0]              texture_position;

  // Divider and start offset
  logic [STEP_W-1:0]             quo;
  logic [HW-1:0]                 rem;
  logic [HW-1:0]                 divisor;
  logic [OFS_W-1:0]              ofs;

  // Output register
  logic                          out_valid;
  logic [wtcs_pkg::SEL_W-1:0]    out_sel;
  logic [wtcs_pkg::TEX_W-1:0]    out_tx;
  logic [wtcs_pkg::TEX_W-1:0]    out_ty;
  logic [wtcs_pkg::COL_W-1:0]    out_col;
  logic [wtcs_pkg::ROW_W-1:0]    out_rw;

  // Combinational setup terms
  logic [wtcs_pkg::SEL_W-1:0]    sel;
  logic                          mirror;
  logic [wtcs_pkg::WIDTH_W-1:0]  wz;
  logic [TXP_W-1:0]              tx_prod;
  logic [wtcs_pkg::WIDTH_W-1:0]  tx;
  logic [wtcs_pkg::WIDTH_W-1:0]  txm;
  logic [HW-1:0]                 hz;
  logic [wtcs_pkg::SEL_W-1:0]    hl_addr;
  logic [wtcs_pkg::HLOG_W-1:0]   hl;
  logic [HW:0]                   shifted;
  logic                          fits;
  logic signed [PROD_W-1:0]      start_prod;
  logic [wtcs_pkg::TEX_W:0]      mask_full;

  assign pixel_in.ready = cmd.in_ready;
  assign cfg.ready      = 1'b1;
  assign stat.out_full  = out_valid && !pixel_out.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cfg_width[i] <= wtcs_pkg::WIDTH_RESET;
        cfg_hlog[i]  <= wtcs_pkg::HLOG_RESET;
      end
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index inside {[wtcs_pkg::REG_EAST_WIDTH:wtcs_pkg::REG_NORTH_WIDTH]}) begin
        cfg_width[cfg.index[1:0]] <= cfg.data;
      end else begin
        cfg_hlog[cfg.index[1:0]] <= cfg.data[wtcs_pkg::HLOG_W-1:0];
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_side <= pixel_in.hit_side;
      it_xpos <= pixel_in.ray_x_positive;
      it_ypos <= pixel_in.ray_y_positive;
      it_frac <= pixel_in.wall_fraction;
      it_h    <= pixel_in.wall_height;
      it_col  <= pixel_in.column;
      it_row  <= pixel_in.row;
    end
  end

  // Texture pick, texel column, height log2 lookup
  always_comb begin
    if (it_side) begin
      sel    = it_ypos ? wtcs_pkg::FACE_SOUTH : wtcs_pkg::FACE_NORTH;
      mirror = it_ypos;
    end else begin
      sel    = it_xpos ? wtcs_pkg::FACE_EAST : wtcs_pkg::FACE_WEST;
      mirror = !it_xpos;
    end
    wz      = (cfg_width[sel] == '0) ? wtcs_pkg::WIDTH_W'(1) : cfg_width[sel];
    tx_prod = TXP_W'(it_frac) * TXP_W'(wz);
    tx      = tx_prod[TXP_W-1:wtcs_pkg::FRAC_BITS];
    txm     = mirror ? (wz - wtcs_pkg::WIDTH_W'(1) - tx) : tx;
    hz      = (it_h == '0) ? HW'(1) : it_h;
    hl_addr = cmd.setup ? sel : current_texture;
    hl      = wtcs_pkg::sat_log2(cfg_hlog[hl_addr]);
  end

  // One restoring division step
  always_comb begin
    shifted = {rem, quo[STEP_W-1]};
    fits    = shifted >= {1'b0, divisor};
  end

  assign start_prod = $signed(ofs) * $signed({1'b0, quo});
  assign mask_full  = ((wtcs_pkg::TEX_W+1)'(1) << hl) - (wtcs_pkg::TEX_W+1)'(1);

  // Column setup, division, start position, stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      current_texture  <= '0;
      texel_column     <= '0;
      position_step    <= '0;
      texture_position <= '0;
    end else begin
      if (cmd.setup) begin
        current_texture <= sel;
        texel_column    <= txm[wtcs_pkg::TEX_W-1:0];
      end
      if (cmd.mul) begin
        position_step    <= quo;
        texture_position <= POS_W'(start_prod);
      end else if (cmd.emit) begin
        texture_position <= texture_position + POS_W'(position_step);
      end
    end
  end

  // Divider registers and start offset
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      quo     <= STEP_W'(1) << (5'(hl) + 5'(wtcs_pkg::FRAC_BITS));
      rem     <= '0;
      divisor <= hz;
      ofs     <= OFS_W'(it_row) + OFS_W'(it_h >> 1) - OFS_W'(SCREEN_HEIGHT / 2);
    end else if (cmd.div_step) begin
      quo <= {quo[STEP_W-2:0], fits};
      rem <= fits ? HW'(shifted - {1'b0, divisor}) : shifted[HW-1:0];
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sel <= current_texture;
      out_tx  <= texel_column;
      out_ty  <= texture_position[wtcs_pkg::FRAC_BITS +: wtcs_pkg::TEX_W]
                 & mask_full[wtcs_pkg::TEX_W-1:0];
      out_col <= it_col;
      out_rw  <= it_row;
    end
  end

  assign pixel_out.valid          = out_valid;
  assign pixel_out.texture_select = out_sel;
  assign pixel_out.texture_x      = out_tx;
  assign pixel_out.texture_y      = out_ty;
  assign pixel_out.out_column     = out_col;
  assign pixel_out.out_row        = out_rw;

endmodule

// ----- sv/wtcs_checker.sv -----
// ----------------------------------------------------------------------------
// wtcs_checker
// Port-level checks on the stepper, attached by bind.
// ----------------------------------------------------------------------------
module wtcs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_first_row,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [wtcs_pkg::TEX_W-1:0] out_texture_y
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_texture_y))
    else $error("stalled result word changed");

  // No result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // A row word into an empty output shows after emit state and output register
  a_row_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_first_row && !out_valid |-> ##2 out_valid)
    else $error("row word result missing");

  // A column start blocks input during column setup
  a_first_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_first_row |=> !in_ready)
    else $error("input taken during column setup");

endmodule

bind wall_texture_coordinate_stepper wtcs_checker u_wtcs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixel_in.valid),
  .in_ready      (pixel_in.ready),
  .in_first_row  (pixel_in.first_row),
  .out_valid     (pixel_out.valid),
  .out_ready     (pixel_out.ready),
  .out_texture_y (pixel_out.texture_y)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wall texture coordinate stepper. A directed
// table, then random columns of pixel words under several texture settings,
// are sent through the valid/ready input. Each texel word that comes back is
// compared field by field against its typed-in word or a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_ROWS  = wtcs_pkg::SCREEN_HEIGHT_DEFAULT;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS  = 172;
  localparam int NUM_PHASES   = 6;
  localparam int LIMIT_NS     = 1000000;

  typedef struct packed {
    logic                          first_row;
    logic                          hit_side;
    logic                          ray_x_positive;
    logic                          ray_y_positive;
    logic [wtcs_pkg::FRAC_W-1:0]   wall_fraction;
    logic [wtcs_pkg::HEIGHT_W-1:0] wall_height;
    logic [wtcs_pkg::COL_W-1:0]    column;
    logic [wtcs_pkg::ROW_W-1:0]    row;
  } pixel_word_t;

  typedef struct packed {
    logic [wtcs_pkg::SEL_W-1:0] texture_select;
    logic [wtcs_pkg::TEX_W-1:0] texture_x;
    logic [wtcs_pkg::TEX_W-1:0] texture_y;
    logic [wtcs_pkg::COL_W-1:0] out_column;
    logic [wtcs_pkg::ROW_W-1:0] out_row;
  } texel_word_t;

  typedef struct packed {
    pixel_word_t pixel;
    logic        typed;
    texel_word_t want;
  } directed_row_t;

  localparam logic [wtcs_pkg::CFG_IDX_W-1:0] WIDTH_REG [4] =
    '{wtcs_pkg::REG_EAST_WIDTH, wtcs_pkg::REG_WEST_WIDTH, wtcs_pkg::REG_SOUTH_WIDTH,
      wtcs_pkg::REG_NORTH_WIDTH};
  localparam logic [wtcs_pkg::CFG_IDX_W-1:0] HLOG_REG [4] =
    '{wtcs_pkg::REG_EAST_HEIGHT_LOG2, wtcs_pkg::REG_WEST_HEIGHT_LOG2,
      wtcs_pkg::REG_SOUTH_HEIGHT_LOG2, wtcs_pkg::REG_NORTH_HEIGHT_LOG2};

  // Directed words; the expected texel word is typed in where it is obvious
  localparam int DIRECTED_N = 16;
  localparam directed_row_t DIRECTED [DIRECTED_N] = '{
    // row before any column start: all state zero
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'd7, 10'd5}, 1'b1,
      '{wtcs_pkg::FACE_EAST, 10'd0, 10'd0, 12'd7, 10'd5}},
    // east face, fraction zero, start position exactly zero
    '{'{1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 16'd1024, 12'd0, 10'd0}, 1'b1,
      '{wtcs_pkg::FACE_EAST, 10'd0, 10'd0, 12'd0, 10'd0}},
    '{'{1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 12'd0, 10'd1}, 1'b0, '0},
    // west face mirrored, zero wall height taken as one
    '{'{1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'd0, 12'hFFF, 10'd512}, 1'b1,
      '{wtcs_pkg::FACE_WEST, 10'd0, 10'd0, 12'hFFF, 10'd512}},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'hFFF, 10'd513}, 1'b0, '0},
    // south face mirrored, tallest wall
    '{'{1'b1, 1'b1, 1'b0, 1'b1, 16'h0000, 16'hFFFF, 12'h555, 10'd0}, 1'b1,
      '{wtcs_pkg::FACE_SOUTH, 10'd63, 10'd31, 12'h555, 10'd0}},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'h555, 10'd1023}, 1'b0, '0},
    // north face, start above the wall top (negative position)
    '{'{1'b1, 1'b1, 1'b0, 1'b0, 16'h8000, 16'd2, 12'hAAA, 10'd0}, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'hAAA, 10'd1}, 1'b0, '0},
    // east face, full fraction, last screen row
    '{'{1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'd1, 12'd0, 10'd1023}, 1'b1,
      '{wtcs_pkg::FACE_EAST, 10'd63, 10'd0, 12'd0, 10'd1023}},
    '{'{1'b1, 1'b1, 1'b1, 1'b1, 16'h0001, 16'd3, 12'd1, 10'd0}, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'd1, 10'd1}, 1'b0, '0},
    '{'{1'b1, 1'b0, 1'b1, 1'b1, 16'h4000, 16'd640, 12'h2A5, 10'd300}, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'h2A5, 10'd301}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b0, 1'b0, 16'hC000, 16'h8000, 12'h35A, 10'd1023}, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'd0, 12'h35A, 10'd0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  wtcs_in_if  pixel_in ();
  wtcs_out_if pixel_out ();
  wtcs_cfg_if cfg ();

  wall_texture_coordinate_stepper #(
    .SCREEN_HEIGHT(SCREEN_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_in),
    .pixel_out(pixel_out),
    .cfg      (cfg)
  );

  always #1 clk = ~clk;

  // Predictor state: texture settings and the column being stepped
  logic [wtcs_pkg::WIDTH_W-1:0] face_width [4];
  logic [wtcs_pkg::HLOG_W-1:0]  face_hlog [4];
  logic [wtcs_pkg::SEL_W-1:0]   tex_now;
  logic [wtcs_pkg::TEX_W-1:0]   column_texel;
  logic [wtcs_pkg::STEP_W-1:0]  row_step;
  logic [wtcs_pkg::POS_W-1:0]   tex_pos;

  texel_word_t pending_texels [$];

  int tx_idle_pct;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen;
  int hold_left;
  int mismatch_count = 0;
  int words_sent = 0;
  int columns_started = 0;
  int texels_checked = 0;
  int settings_used = 1;

  function automatic int unsigned face_log2(logic [wtcs_pkg::SEL_W-1:0] sel);
    return (face_hlog[sel] > wtcs_pkg::HLOG_MAX) ? wtcs_pkg::HLOG_MAX : face_hlog[sel];
  endfunction

  // Step the predictor by one pixel word and return its texel word
  function automatic texel_word_t predict_texel(pixel_word_t w);
    logic [wtcs_pkg::SEL_W-1:0] sel;
    logic                       mirror;
    logic [11:0]                wid;
    logic [31:0]                tx;
    logic [16:0]                h;
    longint                     offset;
    longint                     start;
    texel_word_t                res;
    if (w.first_row) begin
      if (!w.hit_side) begin
        sel    = w.ray_x_positive ? wtcs_pkg::FACE_EAST : wtcs_pkg::FACE_WEST;
        mirror = !w.ray_x_positive;
      end else begin
        sel    = w.ray_y_positive ? wtcs_pkg::FACE_SOUTH : wtcs_pkg::FACE_NORTH;
        mirror = w.ray_y_positive;
      end
      wid = (face_width[sel] == '0) ? 12'd1 : {1'b0, face_width[sel]};
      tx  = (32'(w.wall_fraction) * 32'(wid)) >> wtcs_pkg::FRAC_BITS;
      if (mirror) tx = 32'(wid) - 32'd1 - tx;
      tex_now      = sel;
      column_texel = tx[wtcs_pkg::TEX_W-1:0];
      h        = (w.wall_height == '0) ? 17'd1 : {1'b0, w.wall_height};
      row_step = wtcs_pkg::STEP_W'((64'd1 << (face_log2(sel) + wtcs_pkg::FRAC_BITS))
                                   / 64'(h));
      offset   = longint'(w.row) - longint'(SCREEN_ROWS / 2) + longint'(h >> 1);
      start    = offset * longint'(row_step);
      tex_pos  = start[wtcs_pkg::POS_W-1:0];
    end
    res.texture_select = tex_now;
    res.texture_x      = column_texel;
    res.texture_y      = wtcs_pkg::TEX_W'(tex_pos[wtcs_pkg::POS_W-1:wtcs_pkg::FRAC_BITS] &
                                          ((32'd1 << face_log2(tex_now)) - 32'd1));
    res.out_column     = w.column;
    res.out_row        = w.row;
    tex_pos = tex_pos + wtcs_pkg::POS_W'(row_step);
    return res;
  endfunction

  function automatic void apply_register(logic [wtcs_pkg::CFG_IDX_W-1:0] idx,
                                         logic [wtcs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      wtcs_pkg::REG_EAST_WIDTH:  face_width[wtcs_pkg::FACE_EAST]  = data;
      wtcs_pkg::REG_WEST_WIDTH:  face_width[wtcs_pkg::FACE_WEST]  = data;
      wtcs_pkg::REG_SOUTH_WIDTH: face_width[wtcs_pkg::FACE_SOUTH] = data;
      wtcs_pkg::REG_NORTH_WIDTH: face_width[wtcs_pkg::FACE_NORTH] = data;
      wtcs_pkg::REG_EAST_HEIGHT_LOG2:
        face_hlog[wtcs_pkg::FACE_EAST]  = data[wtcs_pkg::HLOG_W-1:0];
      wtcs_pkg::REG_WEST_HEIGHT_LOG2:
        face_hlog[wtcs_pkg::FACE_WEST]  = data[wtcs_pkg::HLOG_W-1:0];
      wtcs_pkg::REG_SOUTH_HEIGHT_LOG2:
        face_hlog[wtcs_pkg::FACE_SOUTH] = data[wtcs_pkg::HLOG_W-1:0];
      default:
        face_hlog[wtcs_pkg::FACE_NORTH] = data[wtcs_pkg::HLOG_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input pixel_word_t w, input logic typed,
                            input texel_word_t want);
    texel_word_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      pixel_in.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_in.valid          <= 1'b1;
    pixel_in.first_row      <= w.first_row;
    pixel_in.hit_side       <= w.hit_side;
    pixel_in.ray_x_positive <= w.ray_x_positive;
    pixel_in.ray_y_positive <= w.ray_y_positive;
    pixel_in.wall_fraction  <= w.wall_fraction;
    pixel_in.wall_height    <= w.wall_height;
    pixel_in.column         <= w.column;
    pixel_in.row            <= w.row;
    do @(posedge clk); while (pixel_in.ready !== 1'b1);
    predicted = predict_texel(w);
    pending_texels.push_back(typed ? want : predicted);
    words_sent++;
    if (w.first_row) columns_started++;
  endtask

  task automatic write_register(input logic [wtcs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [wtcs_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    apply_register(idx, data);
  endtask

  // Drop valid and hold until every expected texel word is back
  task automatic wait_drained();
    pixel_in.valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
  endtask

  function automatic pixel_word_t random_start();
    pixel_word_t w;
    w.first_row      = 1'b1;
    w.hit_side       = 1'($urandom_range(1));
    w.ray_x_positive = 1'($urandom_range(1));
    w.ray_y_positive = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       w.wall_fraction = '0;
      1:       w.wall_fraction = '1;
      default: w.wall_fraction = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0:       w.wall_height = '0;
      1:       w.wall_height = 16'($urandom_range(1, 4));
      2:       w.wall_height = '1;
      3, 4:    w.wall_height = 16'($urandom);
      default: w.wall_height = 16'($urandom_range(1, 1100));
    endcase
    w.column = 12'($urandom);
    w.row    = 10'($urandom);
    return w;
  endfunction

  // Mostly whole columns with random content, some loose noise words
  task automatic run_columns(input int count);
    pixel_word_t w;
    int          rest;
    int          rows_left;
    rest = count;
    // keep stepping the open column across the register change
    repeat (2) begin
      w = random_start();
      w.first_row = 1'b0;
      send_pixel(w, 1'b0, '0);
      rest--;
    end
    while (rest > 0) begin
      w = random_start();
      if ($urandom_range(9) == 0) begin
        w.first_row = 1'($urandom_range(1));
        send_pixel(w, 1'b0, '0);
        rest--;
      end else begin
        send_pixel(w, 1'b0, '0);
        rest--;
        rows_left = $urandom_range(12);
        while (rows_left > 0 && rest > 0) begin
          w.first_row = 1'b0;
          w.row       = w.row + 1'b1;
          send_pixel(w, 1'b0, '0);
          rows_left--;
          rest--;
        end
      end
    end
  endtask

  // Output side: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pixel_out.ready <= 1'b0;
      hold_seen       <= 0;
      hold_left       <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HOLD_CYCLES;
      pixel_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      pixel_out.ready <= 1'b0;
    end else begin
      pixel_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted texel word with the oldest expectation
  always @(posedge clk) begin
    texel_word_t want;
    if (!rst && pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1) begin
      if (pending_texels.size() == 0) begin
        report_mismatch("unexpected texel word, row", pixel_out.out_row, 0);
      end else begin
        want = pending_texels.pop_front();
        texels_checked++;
        if (pixel_out.texture_select !== want.texture_select)
          report_mismatch("texture_select", pixel_out.texture_select, want.texture_select);
        if (pixel_out.texture_x !== want.texture_x)
          report_mismatch("texture_x", pixel_out.texture_x, want.texture_x);
        if (pixel_out.texture_y !== want.texture_y)
          report_mismatch("texture_y", pixel_out.texture_y, want.texture_y);
        if (pixel_out.out_column !== want.out_column)
          report_mismatch("out_column", pixel_out.out_column, want.out_column);
        if (pixel_out.out_row !== want.out_row)
          report_mismatch("out_row", pixel_out.out_row, want.out_row);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d texel words outstanding", pending_texels.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [wtcs_pkg::WIDTH_W-1:0] wid [4];
    logic [wtcs_pkg::HLOG_W-1:0]  lg [4];
    // drive every input known from time zero
    rst                     = 1'b1;
    pixel_in.valid          = 1'b0;
    pixel_in.first_row      = 1'b0;
    pixel_in.hit_side       = 1'b0;
    pixel_in.ray_x_positive = 1'b0;
    pixel_in.ray_y_positive = 1'b0;
    pixel_in.wall_fraction  = '0;
    pixel_in.wall_height    = '0;
    pixel_in.column         = '0;
    pixel_in.row            = '0;
    cfg.valid               = 1'b0;
    cfg.index               = '0;
    cfg.data                = '0;
    for (int i = 0; i < 4; i++) begin
      face_width[i] = wtcs_pkg::WIDTH_RESET;
      face_hlog[i]  = wtcs_pkg::HLOG_RESET;
    end
    tex_now      = wtcs_pkg::FACE_EAST;
    column_texel = '0;
    row_step     = '0;
    tex_pos      = '0;
    tx_idle_pct  = 24;

    repeat (9) @(posedge clk);
    rst         <= 1'b0;
    rx_idle_pct <= 50;

    // Walk the directed table at reset settings
    for (int i = 0; i < DIRECTED_N; i++)
      send_pixel(DIRECTED[i].pixel, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < 4; i++) begin
        case (p)
          0: begin
            wid[i] = wtcs_pkg::WIDTH_W'($urandom_range(1, 1024));
            lg[i]  = wtcs_pkg::HLOG_W'($urandom_range(0, 10));
          end
          1: begin
            wid[i] = 11'd1;
            lg[i]  = 4'd0;
          end
          2: begin
            wid[i] = 11'd1024;
            lg[i]  = wtcs_pkg::HLOG_MAX;
          end
          3: begin
            // zero width, widths past 1024, log2 past the largest texture
            wid[i] = (i == 0) ? 11'd0 : (i == 1) ? 11'd2047 : 11'd1025 + 11'(i);
            lg[i]  = (i == 0) ? 4'd15 : wtcs_pkg::HLOG_W'(11 + i);
          end
          4: begin
            wid[i] = wtcs_pkg::WIDTH_W'($urandom);
            lg[i]  = wtcs_pkg::HLOG_W'($urandom);
          end
          default: begin
            wid[i] = wtcs_pkg::WIDTH_W'($urandom_range(1, 1024));
            lg[i]  = wtcs_pkg::HLOG_W'($urandom_range(0, 10));
          end
        endcase
      end
      // swap idling sides after two phases, stop idling after four
      if (p == 2) begin
        tx_idle_pct = 50;
        rx_idle_pct <= 24;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      wait_drained();
      for (int i = 0; i < 4; i++) begin
        write_register(WIDTH_REG[i], wid[i]);
        write_register(HLOG_REG[i], wtcs_pkg::CFG_DATA_W'(lg[i]));
      end
      cfg.valid <= 1'b0;
      settings_used++;

      // fill the block while the output side holds off
      if (p == 1) hold_req <= hold_req + 1;
      run_columns(PHASE_WORDS);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pixel words (%0d column starts) under %0d texture settings;",
             words_sent, columns_started, settings_used);
    $display("checked %0d texel words, %0d field mismatches.", texels_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
